// ===== hdl/disparity_to_point_projector_macros.svh =====
// Assertion macros used by the checker file.
`ifndef DISPARITY_TO_POINT_PROJECTOR_MACROS_SVH
`define DISPARITY_TO_POINT_PROJECTOR_MACROS_SVH

// Same-cycle implication, checked in and out of reset.
`define DTP_ASSERT_IMP(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("dtp assertion failed");

// Next-cycle implication, masked while reset is low.
`define DTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dtp assertion failed");

`endif

// ===== hdl/dtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtp_pkg
// Types, widths and constants of the disparity to point projector.
// ----------------------------------------------------------------------------
`default_nettype none
package dtp_pkg;
	localparam int unsigned IMAGE_WIDTH_DEF  = 4096;
	localparam int unsigned IMAGE_HEIGHT_DEF = 4096;
	localparam int unsigned DIM_W      = 17;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned DISP_W     = 16;
	localparam int unsigned POINT_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned FB_W       = 32;
	localparam int unsigned FOCAL_W    = 24;
	localparam int unsigned CENTER_W   = 16;
	localparam int unsigned MAG_W      = 16;
	// quotient bits below the saturation point; one divider stage each
	localparam int unsigned QBITS      = 31;
	localparam int unsigned DIV_DEPTH  = QBITS + 1;
	localparam int unsigned LAT_NW     = MAG_W + FB_W + 10;
	localparam int unsigned LAT_DW     = FOCAL_W + MAG_W;
	localparam int unsigned DEP_NW     = FB_W + 6;
	localparam int unsigned DEP_DW     = MAG_W;

	localparam logic [FB_W-1:0]      FB_RST      = '0;
	localparam logic [FOCAL_W-1:0]   FOCAL_RST   = FOCAL_W'(256);
	localparam logic [CENTER_W-1:0]  CENTER_RST  = '0;
	localparam logic [DISP_W-1:0]    DFLOOR_RST  = '0;
	localparam logic [DISP_W-1:0]    DCEIL_RST   = DISP_W'(32767);
	localparam logic [POINT_W-1:0]   SAT_MAX     = {1'b0, {(POINT_W-1){1'b1}}};
	localparam logic [POINT_W-1:0]   SAT_MIN     = {1'b1, {(POINT_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_BASELINE,
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_DISP_FLOOR,
		REG_DISP_CEILING
	} cfg_reg_t;

	typedef struct packed {
		logic [FB_W-1:0]            fb;
		logic [FOCAL_W-1:0]         fx;
		logic [FOCAL_W-1:0]         fy;
		logic [CENTER_W-1:0]        cx;
		logic [CENTER_W-1:0]        cy;
		logic signed [DISP_W-1:0]   dfloor;
		logic signed [DISP_W-1:0]   dceil;
	} cfg_t;

	typedef struct packed {
		logic [LAT_NW-1:0] num_x;
		logic [LAT_DW-1:0] den_x;
		logic              neg_x;
		logic [LAT_NW-1:0] num_y;
		logic [LAT_DW-1:0] den_y;
		logic              neg_y;
		logic [DEP_NW-1:0] num_z;
		logic [DEP_DW-1:0] den_z;
		logic              neg_z;
	} quot_t;
endpackage
`default_nettype wire

// ===== hdl/dtp_ifs.sv =====
// ----------------------------------------------------------------------------
// dtp channel interfaces
// Pixel, point and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface pixel_if;
	logic                              valid;
	logic                              ready;
	logic [dtp_pkg::COORD_W-1:0]       pixel_column;
	logic [dtp_pkg::COORD_W-1:0]       pixel_row;
	logic signed [dtp_pkg::DISP_W-1:0] disparity_value;
	logic                              disparity_invalid;
	modport source (output valid, pixel_column, pixel_row, disparity_value,
		disparity_invalid, input ready);
	modport sink (input valid, pixel_column, pixel_row, disparity_value,
		disparity_invalid, output ready);
endinterface

interface point_if;
	logic                               valid;
	logic                               ready;
	logic signed [dtp_pkg::POINT_W-1:0] point_x;
	logic signed [dtp_pkg::POINT_W-1:0] point_y;
	logic signed [dtp_pkg::POINT_W-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dtp_pkg::CFG_IDX_W-1:0]   index;
	logic [dtp_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/dtp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dtp_cfg_regs
// Camera and disparity window registers, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none
module dtp_cfg_regs (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cfg_if.sink             wr,
	output dtp_pkg::cfg_t   regs
);
	dtp_pkg::cfg_t regs_q;

	assign wr.ready = 1'b1;
	assign regs     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fb     <= dtp_pkg::FB_RST;
			regs_q.fx     <= dtp_pkg::FOCAL_RST;
			regs_q.fy     <= dtp_pkg::FOCAL_RST;
			regs_q.cx     <= dtp_pkg::CENTER_RST;
			regs_q.cy     <= dtp_pkg::CENTER_RST;
			regs_q.dfloor <= dtp_pkg::DFLOOR_RST;
			regs_q.dceil  <= dtp_pkg::DCEIL_RST;
		end else if (wr.valid) begin
			unique case (dtp_pkg::cfg_reg_t'(wr.index))
				dtp_pkg::REG_FOCAL_BASELINE: regs_q.fb <= wr.data;
				dtp_pkg::REG_FOCAL_X: regs_q.fx <= wr.data[dtp_pkg::FOCAL_W-1:0];
				dtp_pkg::REG_FOCAL_Y: regs_q.fy <= wr.data[dtp_pkg::FOCAL_W-1:0];
				dtp_pkg::REG_CENTER_X: regs_q.cx <= wr.data[dtp_pkg::CENTER_W-1:0];
				dtp_pkg::REG_CENTER_Y: regs_q.cy <= wr.data[dtp_pkg::CENTER_W-1:0];
				dtp_pkg::REG_DISP_FLOOR: regs_q.dfloor <= wr.data[dtp_pkg::DISP_W-1:0];
				dtp_pkg::REG_DISP_CEILING: regs_q.dceil <= wr.data[dtp_pkg::DISP_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/dtp_front.sv =====
// ----------------------------------------------------------------------------
// dtp_front
// Pixel filter, sign/magnitude split and numerator/denominator products.
// ----------------------------------------------------------------------------
`default_nettype none
module dtp_front #(
	parameter int unsigned IMAGE_WIDTH  = dtp_pkg::IMAGE_WIDTH_DEF,
	parameter int unsigned IMAGE_HEIGHT = dtp_pkg::IMAGE_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic [1:0]                        adv,
	input  wire dtp_pkg::cfg_t                     regs,
	input  wire logic [dtp_pkg::COORD_W-1:0]       column,
	input  wire logic [dtp_pkg::COORD_W-1:0]       row,
	input  wire logic signed [dtp_pkg::DISP_W-1:0] disp,
	input  wire logic                              invalid,
	output logic                                   keep,
	output dtp_pkg::quot_t                         ops
);
	localparam int unsigned DW = dtp_pkg::DIM_W;
	localparam int unsigned MW = dtp_pkg::MAG_W;

	logic [DW-1:0]  dx, dy;
	logic           in_image, in_window;
	logic [MW-1:0]  dmag, xmag, ymag;
	logic           dneg;

	logic [MW-1:0]  dmag_s1, xmag_s1, ymag_s1;
	logic           dneg_s1, xneg_s1, yneg_s1;
	dtp_pkg::quot_t ops_s2;

	always_comb begin
		in_image  = (DW'(column) < DW'(IMAGE_WIDTH)) && (DW'(row) < DW'(IMAGE_HEIGHT));
		in_window = (disp >= regs.dfloor) && (disp <= regs.dceil) && (disp != '0);
		keep      = !invalid && in_image && in_window;
		dneg      = disp[dtp_pkg::DISP_W-1];
		dmag      = dneg ? MW'(-disp) : MW'(disp);
		// pixel in Q12.4 minus principal point, 17 bit signed
		dx = DW'({column, 4'b0}) - DW'(regs.cx);
		dy = DW'({row, 4'b0}) - DW'(regs.cy);
		xmag = dx[DW-1] ? MW'(-dx) : dx[MW-1:0];
		ymag = dy[DW-1] ? MW'(-dy) : dy[MW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dmag_s1 <= dmag;
			dneg_s1 <= dneg;
			xmag_s1 <= xmag;
			xneg_s1 <= dx[DW-1];
			ymag_s1 <= ymag;
			yneg_s1 <= dy[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ops_s2.num_x <= {(dtp_pkg::LAT_NW-10)'(xmag_s1) * (dtp_pkg::LAT_NW-10)'(regs.fb),
				10'b0};
			ops_s2.den_x <= dtp_pkg::LAT_DW'(regs.fx) * dtp_pkg::LAT_DW'(dmag_s1);
			ops_s2.neg_x <= xneg_s1 ^ dneg_s1;
			ops_s2.num_y <= {(dtp_pkg::LAT_NW-10)'(ymag_s1) * (dtp_pkg::LAT_NW-10)'(regs.fb),
				10'b0};
			ops_s2.den_y <= dtp_pkg::LAT_DW'(regs.fy) * dtp_pkg::LAT_DW'(dmag_s1);
			ops_s2.neg_y <= yneg_s1 ^ dneg_s1;
			ops_s2.num_z <= {regs.fb, 6'b0};
			ops_s2.den_z <= dmag_s1;
			ops_s2.neg_z <= dneg_s1;
		end
	end

	assign ops = ops_s2;
endmodule
`default_nettype wire

// ===== hdl/dtp_divider.sv =====
// ----------------------------------------------------------------------------
// dtp_divider
// Pipelined restoring divider, one quotient bit per stage, saturating signed
// result from magnitude operands.
// ----------------------------------------------------------------------------
`default_nettype none
module dtp_divider #(
	parameter int unsigned NW = dtp_pkg::LAT_NW,
	parameter int unsigned DW = dtp_pkg::LAT_DW
) (
	input  wire logic                          clk,
	input  wire logic [dtp_pkg::DIV_DEPTH-1:0] adv,
	input  wire logic [NW-1:0]                 num,
	input  wire logic [DW-1:0]                 den,
	input  wire logic                          neg,
	output logic [dtp_pkg::POINT_W-1:0]        res
);
	localparam int unsigned QB = dtp_pkg::QBITS;
	localparam int unsigned ND = dtp_pkg::DIV_DEPTH;
	localparam int unsigned CW = (NW > DW + QB) ? NW : DW + QB;

	logic [NW-1:0] rem_s  [ND];
	logic [DW-1:0] den_s  [ND];
	logic [QB-1:0] quo_s  [ND];
	logic          neg_s  [ND];
	logic          zero_s [ND];
	logic          sat_s  [ND];

	// head stage: quotient at or above 2^31 saturates either way
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			neg_s[0]  <= neg;
			zero_s[0] <= (num == '0);
			sat_s[0]  <= CW'(num) >= (CW'(den) << QB);
		end
	end

	for (genvar j = 1; j < ND; j++) begin : g_bit
		localparam int unsigned B = QB - j;
		logic [CW-1:0] trial;
		logic          ge;
		assign trial = CW'(den_s[j-1]) << B;
		assign ge    = CW'(rem_s[j-1]) >= trial;
		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j]  <= ge ? NW'(CW'(rem_s[j-1]) - trial) : rem_s[j-1];
				quo_s[j]  <= quo_s[j-1] | (ge ? (QB'(1) << B) : '0);
				den_s[j]  <= den_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
				sat_s[j]  <= sat_s[j-1];
			end
		end
	end

	always_comb begin
		if (zero_s[ND-1])
			res = '0;
		else if (sat_s[ND-1])
			res = neg_s[ND-1] ? dtp_pkg::SAT_MIN : dtp_pkg::SAT_MAX;
		else if (neg_s[ND-1])
			res = dtp_pkg::POINT_W'(-{1'b0, quo_s[ND-1]});
		else
			res = {1'b0, quo_s[ND-1]};
	end
endmodule
`default_nettype wire

// ===== hdl/disparity_to_point_projector.sv =====
// A disparity pixel enters with each request; valid pixels (not flagged, inside
// the image and disparity window, non-zero) come out as one saturated Q16.16
// point, others give nothing. One pixel per clock if unstalled: two front stages,
// then 32 stages of three parallel restoring dividers (a saturation check, then
// one quotient bit per stage for 31 bits), then the output register. Each stage
// moves on when it is empty or the stage after it moves, so bubbles close up under
// output back-pressure. Registers are written through the config channel, always
// ready, while no pixels are in flight: the user's duty, unchecked by the block.
// ----------------------------------------------------------------------------
// disparity_to_point_projector
// Stereo disparity pixel to 3D point reprojection, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
module disparity_to_point_projector #(
	parameter int unsigned IMAGE_WIDTH  = dtp_pkg::IMAGE_WIDTH_DEF,
	parameter int unsigned IMAGE_HEIGHT = dtp_pkg::IMAGE_HEIGHT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pixel_if.sink     pixel,
	point_if.source   point,
	cfg_if.sink       cfg
);
	localparam int unsigned ND  = dtp_pkg::DIV_DEPTH;
	localparam int unsigned NST = ND + 3;

	dtp_pkg::cfg_t  regs;
	dtp_pkg::quot_t ops;
	logic           keep;
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;
	logic [dtp_pkg::POINT_W-1:0] res_x, res_y, res_z;
	logic [dtp_pkg::POINT_W-1:0] point_x_q, point_y_q, point_z_q;

	dtp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg),
		.regs   (regs)
	);

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || point.ready;
		for (int k = NST - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign pixel.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= pixel.valid && keep;
			for (int k = 1; k < NST; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	dtp_front #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_front (
		.clk     (clk),
		.adv     (adv[1:0]),
		.regs    (regs),
		.column  (pixel.pixel_column),
		.row     (pixel.pixel_row),
		.disp    (pixel.disparity_value),
		.invalid (pixel.disparity_invalid),
		.keep    (keep),
		.ops     (ops)
	);

	dtp_divider #(.NW(dtp_pkg::LAT_NW), .DW(dtp_pkg::LAT_DW)) u_div_x (
		.clk (clk), .adv (adv[ND+1:2]),
		.num (ops.num_x), .den (ops.den_x), .neg (ops.neg_x), .res (res_x)
	);

	dtp_divider #(.NW(dtp_pkg::LAT_NW), .DW(dtp_pkg::LAT_DW)) u_div_y (
		.clk (clk), .adv (adv[ND+1:2]),
		.num (ops.num_y), .den (ops.den_y), .neg (ops.neg_y), .res (res_y)
	);

	dtp_divider #(.NW(dtp_pkg::DEP_NW), .DW(dtp_pkg::DEP_DW)) u_div_z (
		.clk (clk), .adv (adv[ND+1:2]),
		.num (ops.num_z), .den (ops.den_z), .neg (ops.neg_z), .res (res_z)
	);

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			point_x_q <= res_x;
			point_y_q <= res_y;
			point_z_q <= res_z;
		end
	end

	assign point.valid   = vld_q[NST-1];
	assign point.point_x = point_x_q;
	assign point.point_y = point_y_q;
	assign point.point_z = point_z_q;
endmodule
`default_nettype wire

// ===== hdl/dtp_checker.sv =====
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks on the projector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disparity_to_point_projector_macros.svh"
module dtp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [dtp_pkg::POINT_W-1:0] out_x,
	input wire logic [dtp_pkg::POINT_W-1:0] out_y,
	input wire logic [dtp_pkg::POINT_W-1:0] out_z,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready
);
	// held point must not change or vanish
	`DTP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
	// empty output stage means the whole pipe can move
	`DTP_ASSERT_IMP(a_in_ready, clk, !out_valid, in_ready)
	`DTP_ASSERT_IMP(a_rst_empty, clk, !arst_n, !out_valid)
	`DTP_ASSERT_IMP(a_cfg_ready, clk, cfg_valid, cfg_ready)
endmodule

bind disparity_to_point_projector dtp_checker u_dtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixel.ready),
	.out_valid (point.valid),
	.out_ready (point.ready),
	.out_x     (point.point_x),
	.out_y     (point.point_y),
	.out_z     (point.point_z),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
`default_nettype wire

// ===== test/tb_disparity_to_point_projector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disparity_to_point_projector
// Drives disparity pixels with random gaps and output stalls, predicts each
// projected point from the register settings and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_disparity_to_point_projector;

	typedef struct packed {
		logic [dtp_pkg::COORD_W-1:0]       col;
		logic [dtp_pkg::COORD_W-1:0]       row;
		logic signed [dtp_pkg::DISP_W-1:0] disp;
		logic                              inv;
	} pix_t;

	typedef struct packed {
		logic signed [dtp_pkg::POINT_W-1:0] x;
		logic signed [dtp_pkg::POINT_W-1:0] y;
		logic signed [dtp_pkg::POINT_W-1:0] z;
	} pt_t;

	typedef struct {
		pix_t pix;
		bit   known;
		bit   drop;
		pt_t  pt;
	} row_t;

	localparam int LATENCY   = 40;
	localparam int MAX_CYCLE = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	pixel_if pix_ch ();
	point_if pt_ch ();
	cfg_if   cfg_ch ();

	disparity_to_point_projector dut (
		.clk(clk), .arst_n(arst_n), .pixel(pix_ch.sink), .point(pt_ch.source),
		.cfg(cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register shadow
	logic [dtp_pkg::FB_W-1:0]          fb;
	logic [dtp_pkg::FOCAL_W-1:0]       fx, fy;
	logic [dtp_pkg::CENTER_W-1:0]      cx, cy;
	logic signed [dtp_pkg::DISP_W-1:0] dfloor, dceil;

	pt_t pending_points[$];
	int  errors = 0;
	int  cycles = 0;
	bit  hold_off = 0;
	bit  stim_done = 0;

	function automatic logic [dtp_pkg::POINT_W-1:0] sat_quot(logic [127:0] num,
			logic [127:0] den, bit neg);
		logic [127:0] q;
		if (num == 0)
			return '0;
		if (den == 0)
			return neg ? dtp_pkg::SAT_MIN : dtp_pkg::SAT_MAX;
		q = num / den;
		if (neg)
			return (q >= 128'h8000_0000) ? dtp_pkg::SAT_MIN : dtp_pkg::POINT_W'(-q);
		return (q > 128'h7FFF_FFFF) ? dtp_pkg::SAT_MAX : dtp_pkg::POINT_W'(q);
	endfunction

	function automatic logic [dtp_pkg::POINT_W-1:0] lateral_coord(
			logic [dtp_pkg::COORD_W-1:0] p, logic [dtp_pkg::CENTER_W-1:0] c,
			logic [dtp_pkg::FOCAL_W-1:0] f, logic [15:0] dmag, bit dneg);
		longint delta;
		logic [127:0] mag;
		delta = longint'(p) * 16 - longint'(c);
		mag = (delta < 0) ? 128'(-delta) : 128'(delta);
		return sat_quot(mag * fb * 1024, 128'(f) * dmag, (delta < 0) != dneg);
	endfunction

	// returns 1 when the pixel yields a point
	function automatic bit project_pixel(pix_t p, output pt_t pt);
		bit dneg;
		logic [15:0] dmag;
		pt = '0;
		if (p.inv || p.disp < dfloor || p.disp > dceil || p.disp == 0)
			return 0;
		dneg = p.disp < 0;
		dmag = dneg ? 16'(-int'(p.disp)) : 16'(p.disp);
		pt.x = lateral_coord(p.col, cx, fx, dmag, dneg);
		pt.y = lateral_coord(p.row, cy, fy, dmag, dneg);
		pt.z = sat_quot(128'(fb) * 64, 128'(dmag), dneg);
		return 1;
	endfunction

	// idle the pixel channel for a random stretch
	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		if (n > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(dtp_pkg::cfg_reg_t idx, logic [dtp_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			dtp_pkg::REG_FOCAL_BASELINE: fb = val;
			dtp_pkg::REG_FOCAL_X:        fx = val[dtp_pkg::FOCAL_W-1:0];
			dtp_pkg::REG_FOCAL_Y:        fy = val[dtp_pkg::FOCAL_W-1:0];
			dtp_pkg::REG_CENTER_X:       cx = val[dtp_pkg::CENTER_W-1:0];
			dtp_pkg::REG_CENTER_Y:       cy = val[dtp_pkg::CENTER_W-1:0];
			dtp_pkg::REG_DISP_FLOOR:     dfloor = val[dtp_pkg::DISP_W-1:0];
			dtp_pkg::REG_DISP_CEILING:   dceil = val[dtp_pkg::DISP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// offer the request, queue its expectation when taken; valid stays up for the next
	task automatic send_pixel(pix_t p, bit known, bit drop, pt_t given);
		pt_t pt;
		bit hit;
		hit = project_pixel(p, pt);
		if (known) begin
			if (hit == drop || (hit && pt != given)) begin
				$display("%0t: predictor disagrees with table, exp drop=%0b %h, got %0b %h",
					$time, drop, given, !hit, pt);
				errors++;
			end
		end
		pix_ch.valid             <= 1'b1;
		pix_ch.pixel_column      <= p.col;
		pix_ch.pixel_row         <= p.row;
		pix_ch.disparity_value   <= p.disp;
		pix_ch.disparity_invalid <= p.inv;
		do @(posedge clk); while (!pix_ch.ready);
		if (hit)
			pending_points = {pending_points, pt};
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		p.col = $urandom;
		p.row = $urandom;
		case ($urandom_range(0, 3))
			0: p.disp = $urandom;
			1: p.disp = $urandom_range(1, 64 * 64);
			default: p.disp = $urandom_range(16, 2048);
		endcase
		p.inv = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	task automatic random_phase(int n);
		repeat (n) begin
			send_pixel(rand_pixel(), 0, 0, '0);
			if ($urandom_range(0, 1))
				gap();
		end
	endtask

	row_t stim[$];

	function automatic row_t mk(logic [11:0] c, logic [11:0] r, logic [15:0] d, bit i,
			bit known = 0, bit drop = 0, pt_t pt = '0);
		row_t t;
		t.pix = '{c, r, d, i};
		t.known = known;
		t.drop = drop;
		t.pt = pt;
		return t;
	endfunction

	initial begin
		pix_ch.valid = 0; pix_ch.pixel_column = 0; pix_ch.pixel_row = 0;
		pix_ch.disparity_value = 0; pix_ch.disparity_invalid = 0;
		cfg_ch.valid = 0; cfg_ch.index = dtp_pkg::REG_FOCAL_BASELINE; cfg_ch.data = 0;
		fb = dtp_pkg::FB_RST; fx = dtp_pkg::FOCAL_RST; fy = dtp_pkg::FOCAL_RST;
		cx = dtp_pkg::CENTER_RST; cy = dtp_pkg::CENTER_RST;
		dfloor = dtp_pkg::DFLOOR_RST; dceil = dtp_pkg::DCEIL_RST;
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fb 0 gives all-zero points
		stim = {stim, mk(12'd5, 12'd7, 16'd64, 0, 1, 0, '0)};
		stim = {stim, mk(12'd5, 12'd7, 16'd0, 0, 1, 1)};
		stim = {stim, mk(12'd5, 12'd7, 16'hFFC0, 0, 1, 1)};
		stim = {stim, mk(12'd5, 12'd7, 16'd64, 1, 1, 1)};
		foreach (stim[k])
			send_pixel(stim[k].pix, stim[k].known, stim[k].drop, stim[k].pt);
		drain();

		// unit focal, baseline one: z = 1.0 at d = 1.0
		write_reg(dtp_pkg::REG_FOCAL_BASELINE, 32'h0001_0000);
		write_reg(dtp_pkg::REG_DISP_FLOOR, 32'h0000_8000);
		write_reg(dtp_pkg::REG_DISP_CEILING, 32'h0000_7FFF);
		stim.delete();
		stim = {stim, mk(12'd0, 12'd0, 16'd64, 0, 1, 0, '{32'sd0, 32'sd0, 32'sh10000})};
		stim = {stim, mk(12'hFFF, 12'hFFF, 16'sh7FFF, 0)};
		stim = {stim, mk(12'hFFF, 12'd0, 16'sh8000, 0)};
		stim = {stim, mk(12'd0, 12'hFFF, 16'd1, 0)};
		stim = {stim, mk(12'd1, 12'd1, 16'hFFFF, 0)};
		stim = {stim, mk(12'hAAA, 12'h555, 16'sh5555, 0)};
		foreach (stim[k])
			send_pixel(stim[k].pix, stim[k].known, stim[k].drop, stim[k].pt);
		drain();

		// extremes: zero focal, top baseline, top centre, floor above ceiling
		write_reg(dtp_pkg::REG_FOCAL_BASELINE, 32'hFFFF_FFFF);
		write_reg(dtp_pkg::REG_FOCAL_X, 32'h0);
		write_reg(dtp_pkg::REG_FOCAL_Y, 32'hFF_FFFF);
		write_reg(dtp_pkg::REG_CENTER_X, 32'hFFFF);
		write_reg(dtp_pkg::REG_CENTER_Y, 32'h0);
		stim.delete();
		stim = {stim, mk(12'd0, 12'd0, 16'd1, 0)};
		stim = {stim, mk(12'hFFF, 12'hFFF, 16'sh8000, 0)};
		stim = {stim, mk(12'hFFF, 12'd3, 16'hFFFF, 0)};
		stim = {stim, mk(12'd100, 12'd100, 16'sh7FFF, 0)};
		foreach (stim[k])
			send_pixel(stim[k].pix, stim[k].known, stim[k].drop, stim[k].pt);
		drain();
		write_reg(dtp_pkg::REG_DISP_FLOOR, 32'h0000_0100);
		write_reg(dtp_pkg::REG_DISP_CEILING, 32'h0000_00FF);
		send_pixel('{12'd1, 12'd1, 16'sh00FF, 1'b0}, 1, 1, '0);
		send_pixel('{12'd1, 12'd1, 16'sh0100, 1'b0}, 1, 1, '0);
		drain();

		// random settings: a pinned window, then several random ones
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(dtp_pkg::REG_FOCAL_BASELINE, (ph == 0) ? 32'h0002_0000 : $urandom);
			write_reg(dtp_pkg::REG_FOCAL_X,
				(ph == 1) ? 32'd1 : $urandom_range(64, 4096 * 256));
			write_reg(dtp_pkg::REG_FOCAL_Y,
				(ph == 2) ? 32'hFF_FFFF : $urandom_range(1, 1 << 24));
			write_reg(dtp_pkg::REG_CENTER_X, $urandom);
			write_reg(dtp_pkg::REG_CENTER_Y, $urandom);
			write_reg(dtp_pkg::REG_DISP_FLOOR,
				(ph < 3) ? 32'hFFFF_8000 : $urandom_range(0, 200));
			write_reg(dtp_pkg::REG_DISP_CEILING,
				(ph < 3) ? 32'h7FFF : $urandom_range(1000, 32767));
			if (ph == 1)
				hold_off = 1;
			random_phase(200);
			drain();
		end
		stim_done = 1;
	end

	// receiver: random stalls; one long hold-off to back up the pipeline
	initial begin
		int n;
		pt_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				hold_off = 0;
				pt_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			pt_ch.ready <= 1'b1;
			if ($urandom_range(0, 2) == 0) begin
				@(posedge clk);
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
				pt_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		pt_t exp_pt;
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h z=%h", $time, pt_ch.point_x,
					pt_ch.point_y, pt_ch.point_z);
				errors++;
			end else begin
				exp_pt = pending_points.pop_front();
				if (pt_ch.point_x !== exp_pt.x) begin
					$display("%0t: point_x exp %h got %h", $time, exp_pt.x, pt_ch.point_x);
					errors++;
				end
				if (pt_ch.point_y !== exp_pt.y) begin
					$display("%0t: point_y exp %h got %h", $time, exp_pt.y, pt_ch.point_y);
					errors++;
				end
				if (pt_ch.point_z !== exp_pt.z) begin
					$display("%0t: point_z exp %h got %h", $time, exp_pt.z, pt_ch.point_z);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stim_done) begin
			if (pending_points.size() != 0) begin
				$display("%0t: %0d points never arrived", $time, pending_points.size());
				errors++;
			end
			if (errors == 0)
				$display("tb_disparity_to_point_projector: PASS");
			else
				$display("tb_disparity_to_point_projector: FAIL");
			$finish;
		end else if (cycles >= MAX_CYCLE) begin
			$display("%0t: timeout", $time);
			$display("tb_disparity_to_point_projector: FAIL");
			$finish;
		end
	end
endmodule
`default_nettype wire
